// ===== hw/rtl/mean_filter_3x3_unit_defines.svh =====
// Assertion macros shared by the mean filter checker.
`ifndef MEAN_FILTER_3X3_UNIT_DEFINES_SVH
`define MEAN_FILTER_3X3_UNIT_DEFINES_SVH

// Property on the filter clock; the caller adds disable iff where wanted
`define MF3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

// Implication into the next cycle, suspended while in reset
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mf3_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 mean filter.
package mf3_pkg;

    localparam int MAX_SIZE_DEF = 32;
    localparam int SIZE_W       = 6;
    localparam int PIX_W        = 8;
    localparam int POS_OUT_W    = 5;
    localparam int SUM_W        = 12;   // nine 8-bit pixels
    localparam int RECIP_W      = 15;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_W       = SUM_W + RECIP_W;
    localparam int M_DATA_W     = 24;   // 18 bits of fields, padded to bytes

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd10;

    // Reciprocals scaled by 2^16, exact for every reachable sum
    localparam logic [RECIP_W-1:0] RECIP_DIV4 = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 15'd10923;
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = 15'd7282;

    // Neighbour offset codes within the 3x3 window
    localparam logic [1:0] TAP_LO  = 2'd0;
    localparam logic [1:0] TAP_MID = 2'd1;
    localparam logic [1:0] TAP_HI  = 2'd2;

    // Which result of the current item is being produced
    typedef enum logic [1:0] {
        JOB_DIAG,
        JOB_EDGE,
        JOB_FLUSH_FIRST,
        JOB_FLUSH_NEXT
    } job_t;

    typedef struct packed {
        logic       accept;
        logic       job_load;
        job_t       job_kind;
        logic       tap_en;
        logic [1:0] tap_dr;
        logic [1:0] tap_dc;
        logic       mult_en;
        logic       out_load;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic has_diag;
        logic has_edge;
        logic has_flush;
        logic col_end;
        logic out_free;
    } status_t;

    // Line-store slot arithmetic, rows kept modulo three
    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    // Scaled reciprocal of the neighbour count (4, 6 or 9)
    function automatic logic [RECIP_W-1:0] recip(input logic full_rows,
                                                 input logic full_cols);
        logic [RECIP_W-1:0] res;
        if (full_rows && full_cols) begin
            res = RECIP_DIV9;
        end else if (full_rows || full_cols) begin
            res = RECIP_DIV6;
        end else begin
            res = RECIP_DIV4;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mf3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/mf3_datapath.sv =====
// Datapath: positions, line store, window accumulator, divider and output register.
module mf3_datapath #(
    parameter int MAX_SIZE = mf3_pkg::MAX_SIZE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mf3_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic [mf3_pkg::PIX_W-1:0]      s_tdata,
    input  mf3_pkg::cmd_t                  cmd,
    output mf3_pkg::status_t               status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mf3_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import mf3_pkg::*;

    localparam int PW    = $clog2(MAX_SIZE);
    localparam int DEPTH = 3 * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] n_eff, nm1;

    logic [PW-1:0] row_reg, row_next, col_reg, col_next;
    logic [1:0]    slot_reg, slot_next;

    logic [PW-1:0] item_r_reg, item_c_reg;
    logic [1:0]    item_slot_reg;

    logic [PW-1:0] out_r_reg, out_r_next, out_c_reg, out_c_next;
    logic [1:0]    out_slot_reg, out_slot_next;

    logic              tap_ok_reg;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg;

    logic                 m_tvalid_reg;
    logic [PIX_W-1:0]     sm_reg;
    logic [POS_OUT_W-1:0] orow_reg, ocol_reg;
    logic                 last_reg, frame_reg;

    logic [AW-1:0]    waddr, raddr;
    logic [PIX_W-1:0] rdata;

    logic          row_ok, col_ok;
    logic [PW-1:0] tap_c;
    logic [1:0]    tap_slot;
    logic          full_rows, full_cols;
    logic [PW+POS_OUT_W-1:0] r_ext, c_ext;

    // Base address of a row slot
    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] b;
        case (s)
            2'd1:    b = AW'(MAX_SIZE);
            2'd2:    b = AW'(2 * MAX_SIZE);
            default: b = '0;
        endcase
        return b;
    endfunction

    // Effective side length, clamped to the supported range
    always_comb begin
        if (size_reg < SIZE_W'(2)) begin
            n_eff = SIZE_W'(2);
        end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
            n_eff = SIZE_W'(MAX_SIZE);
        end else begin
            n_eff = size_reg;
        end
        nm1 = n_eff - SIZE_W'(1);
    end

    // Input position, advanced on every accepted item and reset to row 0 column 0 by a size write
    always_comb begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (cfg_wr_en) begin
            size_next = cfg_wr_data;
            row_next  = '0;
            col_next  = '0;
            slot_next = 2'd0;
        end else if (cmd.accept) begin
            if (SIZE_W'(col_reg) == nm1) begin
                col_next = '0;
                if (SIZE_W'(row_reg) == nm1) begin
                    row_next  = '0;
                    slot_next = 2'd0;
                end else begin
                    row_next  = row_reg + PW'(1);
                    slot_next = slot_inc(slot_reg);
                end
            end else begin
                col_next = col_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            slot_reg <= 2'd0;
        end else begin
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            slot_reg <= slot_next;
        end
    end

    // Latch the position of the item just taken
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_r_reg    <= row_reg;
            item_c_reg    <= col_reg;
            item_slot_reg <= slot_reg;
        end
    end

    assign status.has_diag  = (item_r_reg != '0) && (item_c_reg != '0);
    assign status.has_edge  = SIZE_W'(item_c_reg) == nm1;
    assign status.has_flush = (SIZE_W'(item_r_reg) == nm1) && (SIZE_W'(item_c_reg) == nm1);
    assign status.col_end   = SIZE_W'(out_c_reg) == nm1;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // Position of the result to compute
    always_comb begin
        out_r_next    = out_r_reg;
        out_c_next    = out_c_reg;
        out_slot_next = out_slot_reg;
        unique case (cmd.job_kind)
            JOB_DIAG: begin
                out_r_next    = item_r_reg - PW'(1);
                out_c_next    = item_c_reg - PW'(1);
                out_slot_next = slot_dec(item_slot_reg);
            end
            JOB_EDGE: begin
                out_r_next    = item_r_reg - PW'(1);
                out_c_next    = item_c_reg;
                out_slot_next = slot_dec(item_slot_reg);
            end
            JOB_FLUSH_FIRST: begin
                out_r_next    = item_r_reg;
                out_c_next    = '0;
                out_slot_next = item_slot_reg;
            end
            JOB_FLUSH_NEXT: begin
                out_c_next = out_c_reg + PW'(1);
            end
            default: begin
                out_c_next = out_c_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.job_load) begin
            out_r_reg    <= out_r_next;
            out_c_reg    <= out_c_next;
            out_slot_reg <= out_slot_next;
        end
    end

    // Neighbour address and in-image check for the current tap
    always_comb begin
        case (cmd.tap_dr)
            TAP_LO: begin
                row_ok   = out_r_reg != '0;
                tap_slot = slot_dec(out_slot_reg);
            end
            TAP_HI: begin
                row_ok   = SIZE_W'(out_r_reg) != nm1;
                tap_slot = slot_inc(out_slot_reg);
            end
            default: begin
                row_ok   = 1'b1;
                tap_slot = out_slot_reg;
            end
        endcase
        case (cmd.tap_dc)
            TAP_LO: begin
                col_ok = out_c_reg != '0;
                tap_c  = out_c_reg - PW'(1);
            end
            TAP_HI: begin
                col_ok = SIZE_W'(out_c_reg) != nm1;
                tap_c  = out_c_reg + PW'(1);
            end
            default: begin
                col_ok = 1'b1;
                tap_c  = out_c_reg;
            end
        endcase
    end

    assign waddr = slot_base(slot_reg) + AW'(col_reg);
    assign raddr = slot_base(tap_slot) + AW'(tap_c);

    mf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (waddr),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Window sum; read data arrives in the cycle after its tap
    always_comb begin
        acc_next = acc_reg;
        if (cmd.job_load) begin
            acc_next = '0;
        end else if (tap_ok_reg) begin
            acc_next = acc_reg + SUM_W'(rdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_ok_reg <= 1'b0;
        end else begin
            tap_ok_reg <= cmd.tap_en && row_ok && col_ok;
        end
    end

    assign full_rows = (out_r_reg != '0) && (SIZE_W'(out_r_reg) != nm1);
    assign full_cols = (out_c_reg != '0) && (SIZE_W'(out_c_reg) != nm1);

    // Division by 4, 6 or 9 as a reciprocal multiply
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.mult_en) begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(recip(full_rows, full_cols));
        end
    end

    assign r_ext = {{POS_OUT_W{1'b0}}, out_r_reg};
    assign c_ext = {{POS_OUT_W{1'b0}}, out_c_reg};

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sm_reg    <= prod_reg[RECIP_SHIFT +: PIX_W];
            orow_reg  <= r_ext[POS_OUT_W-1:0];
            ocol_reg  <= c_ext[POS_OUT_W-1:0];
            last_reg  <= cmd.out_last;
            frame_reg <= (SIZE_W'(out_r_reg) == nm1) && (SIZE_W'(out_c_reg) == nm1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({ocol_reg, orow_reg, sm_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = frame_reg;
endmodule

// ===== hw/rtl/mf3_ctrl.sv =====
// Controller: sequences the results of each item and the window reads.
module mf3_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              cfg_wr_en,
    input  mf3_pkg::status_t  status,
    output mf3_pkg::cmd_t     cmd
);
    import mf3_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_TAP,
        ST_FINISH,
        ST_MULT,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    job_t       job_reg, job_next;
    logic [1:0] dr_reg, dr_next, dc_reg, dc_next;

    logic more;
    job_t more_kind;

    // Is there a further result for this item after the current one
    always_comb begin
        unique case (job_reg) inside
            JOB_DIAG: begin
                more      = status.has_edge;
                more_kind = JOB_EDGE;
            end
            JOB_EDGE: begin
                more      = status.has_flush;
                more_kind = JOB_FLUSH_FIRST;
            end
            JOB_FLUSH_FIRST, JOB_FLUSH_NEXT: begin
                more      = !status.col_end;
                more_kind = JOB_FLUSH_NEXT;
            end
            default: begin
                more      = 1'b0;
                more_kind = JOB_DIAG;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr_en;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        job_next     = job_reg;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        cmd          = '0;
        cmd.job_kind = job_reg;
        cmd.tap_dr   = dr_reg;
        cmd.tap_dc   = dc_reg;
        cmd.out_last = !more;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid && s_tready;
                if (cmd.accept) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                job_next   = JOB_DIAG;
                state_next = status.has_diag ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                cmd.job_load = 1'b1;
                dr_next      = TAP_LO;
                dc_next      = TAP_LO;
                state_next   = ST_TAP;
            end
            ST_TAP: begin
                cmd.tap_en = 1'b1;
                if (dc_reg == TAP_HI) begin
                    dc_next = TAP_LO;
                    if (dr_reg == TAP_HI) begin
                        state_next = ST_FINISH;
                    end else begin
                        dr_next = dr_reg + 2'd1;
                    end
                end else begin
                    dc_next = dc_reg + 2'd1;
                end
            end
            ST_FINISH: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (more) begin
                        job_next   = more_kind;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_DIAG;
            dr_reg    <= TAP_LO;
            dc_reg    <= TAP_LO;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            dr_reg    <= dr_next;
            dc_reg    <= dc_next;
        end
    end
endmodule

// ===== hw/rtl/mean_filter_3x3_unit.sv =====
// Each result of an accepted item takes nine window reads through the line store's
// single read port, then accumulate, multiply and load; the load waits until the output
// register is free. An item gives k results (k = 0, 1, 2 or n+2), and the next item
// is taken only once the last result of the item before it is loaded.
// Reset (aresetn low, synchronous) sets the size to 10, position to row 0 column 0,
// and empties the output register; the line store is not cleared.
module mean_filter_3x3_unit #(
    parameter int MAX_SIZE = mf3_pkg::MAX_SIZE_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // image_size register
    input  logic                         cfg_wr_en,
    input  logic [mf3_pkg::SIZE_W-1:0]   cfg_wr_data,
    // input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mf3_pkg::PIX_W-1:0]    s_tdata,   // [7:0] pixel_value
    // result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mf3_pkg::M_DATA_W-1:0] m_tdata,   // [7:0] smoothed_value,
                                                    // [12:8] out_row, [17:13] out_column
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tuser    // last_of_frame
);
    import mf3_pkg::*;

    cmd_t    cmd;
    status_t status;

    mf3_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_wr_en (cfg_wr_en),
        .status    (status),
        .cmd       (cmd)
    );

    mf3_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );
endmodule

// ===== hw/rtl/mf3_checker.sv =====
// Port-level checks of the mean filter, bound to the top level.
`include "mean_filter_3x3_unit_defines.svh"

module mf3_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mf3_pkg::M_DATA_W-1:0] m_tdata,
    input logic                         m_tlast,
    input logic                         m_tuser
);
    // Output register empty after reset
    `MF3_ASSERT(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

    // A stalled result holds
    `MF3_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
        "stalled result changed")

    // Bottom-right pixel ends the flush run
    `MF3_ASSERT(a_frame_last, disable iff (!aresetn) m_tvalid && m_tuser |-> m_tlast,
        "frame end without run end")

    // Bottom-right pixel sits on the diagonal
    `MF3_ASSERT(a_frame_diag,
        disable iff (!aresetn) m_tvalid && m_tuser |-> m_tdata[17:13] == m_tdata[12:8],
        "frame end off the diagonal")

    // No new item while a run is still being delivered
    `MF3_ASSERT(a_run_busy, disable iff (!aresetn) m_tvalid && !m_tlast |-> !s_tready,
        "item taken in the middle of a run")
endmodule

bind mean_filter_3x3_unit mf3_checker u_mf3_checker (.*);
